/* sv/llp_pkg.sv */
// llp_pkg: shared types, codes and sizes for the ll(1) predictive parse engine
// no dependencies; used by the config block, the core and the top level
package llp_pkg;

  // default sizes
  localparam int unsigned NONTERMINALS_DEF = 32;
  localparam int unsigned TERMINALS_DEF    = 32;
  localparam int unsigned PRODUCTIONS_DEF  = 64;
  localparam int unsigned MAX_RHS_DEF      = 8;
  localparam int unsigned STACK_DEPTH_DEF  = 64;
  localparam int unsigned MAX_EXPAND_DEF   = 31;

  // memory geometry follows the field widths
  localparam int unsigned TBL_AW = 10;
  localparam int unsigned RHS_AW = 9;
  localparam int unsigned LEN_AW = 6;
  localparam int unsigned STK_AW = 6;

  // input kinds
  localparam logic [2:0] KIND_CELL  = 3'd0;
  localparam logic [2:0] KIND_SYM   = 3'd1;
  localparam logic [2:0] KIND_LEN   = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_TOKEN = 3'd4;

  // result actions
  localparam logic [2:0] ACT_ACK    = 3'd0;
  localparam logic [2:0] ACT_EXPAND = 3'd1;
  localparam logic [2:0] ACT_MATCH  = 3'd2;
  localparam logic [2:0] ACT_ACCEPT = 3'd3;
  localparam logic [2:0] ACT_ERROR  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_EMPTY    = 3'd1;
  localparam logic [2:0] ERR_AMBIG    = 3'd2;
  localparam logic [2:0] ERR_BADTOK   = 3'd3;
  localparam logic [2:0] ERR_MISMATCH = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;
  localparam logic [2:0] ERR_LIMIT    = 3'd6;

  // cell states
  localparam logic [1:0] CELL_EMPTY  = 2'd0;
  localparam logic [1:0] CELL_SINGLE = 2'd1;

  // register indexes
  localparam logic REG_START = 1'b0;
  localparam logic REG_TCNT  = 1'b1;

  typedef struct packed {
    logic [5:0] start_sym;
    logic [4:0] terminal_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_TOP,
    ST_CELL,
    ST_LEN,
    ST_PUSH
  } state_e;

endpackage

/* sv/llp_if.sv */
// llp_if: valid/ready channel interfaces for input items and result items
// depends on nothing but the field widths of the parse engine
interface llp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [4:0] nonterminal;
  logic [4:0] column;
  logic [5:0] production;
  logic [1:0] cell_state;
  logic [2:0] position;
  logic [5:0] rhs_symbol;
  logic [3:0] rhs_length;
  logic [4:0] token;

  modport source (output valid, kind, nonterminal, column, production, cell_state,
                  position, rhs_symbol, rhs_length, token, input ready);
  modport sink   (input valid, kind, nonterminal, column, production, cell_state,
                  position, rhs_symbol, rhs_length, token, output ready);
endinterface

interface llp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [5:0] applied_production;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, action, applied_production, error_code, last,
                  input ready);
  modport sink   (input valid, action, applied_production, error_code, last,
                  output ready);
endinterface

/* sv/llp_cfg.sv */
// llp_cfg: apb-style register port holding start symbol and terminal count
// depends on llp_pkg
module llp_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output llp_pkg::cfg_t     cfg_o
);
  import llp_pkg::*;

  logic [5:0] start_q, start_d;
  logic [4:0] tcnt_q, tcnt_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    start_d = start_q;
    tcnt_d  = tcnt_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_START: start_d = pwdata[5:0];
        REG_TCNT:  tcnt_d  = pwdata[4:0];
        default:   start_d = start_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 6'd32;
      tcnt_q  <= 5'd31;
    end else begin
      start_q <= start_d;
      tcnt_q  <= tcnt_d;
    end
  end

  assign prdata = (paddr[2] == REG_TCNT) ? {27'd0, tcnt_q} : {26'd0, start_q};
  assign cfg_o  = '{start_sym: start_q, terminal_count: tcnt_q};

endmodule

/* sv/llp_core.sv */
// llp_core: parse sequencer around the table, rule, length and stack memories
// depends on llp_pkg and llp_if
module llp_core #(
  parameter int unsigned NONTERMINALS = llp_pkg::NONTERMINALS_DEF,
  parameter int unsigned TERMINALS    = llp_pkg::TERMINALS_DEF,
  parameter int unsigned PRODUCTIONS  = llp_pkg::PRODUCTIONS_DEF,
  parameter int unsigned MAX_RHS      = llp_pkg::MAX_RHS_DEF,
  parameter int unsigned STACK_DEPTH  = llp_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_EXPAND   = llp_pkg::MAX_EXPAND_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  llp_pkg::cfg_t cfg_i,
  llp_in_if.sink        in_i,
  llp_out_if.source     out_o
);
  import llp_pkg::*;

  // memories
  logic [7:0] tbl_mem [2**TBL_AW];
  logic [5:0] rhs_mem [2**RHS_AW];
  logic [3:0] len_mem [2**LEN_AW];
  logic [5:0] stk_mem [2**STK_AW];

  logic              tbl_we, rhs_we, len_we, stk_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [RHS_AW-1:0] rhs_waddr, rhs_raddr;
  logic [LEN_AW-1:0] len_waddr, len_raddr;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]        tbl_wdata, tbl_rdata_q;
  logic [5:0]        rhs_wdata, rhs_rdata_q;
  logic [3:0]        len_wdata, len_rdata_q;
  logic [5:0]        stk_wdata, stk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (rhs_we) rhs_mem[rhs_waddr] <= rhs_wdata;
    rhs_rdata_q <= rhs_mem[rhs_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata_q <= len_mem[len_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  // control state
  state_e            state_q, state_d;
  logic [TBL_AW-1:0] clr_q, clr_d;
  logic [6:0]        sp_q, sp_d;
  logic              run_q, run_d;
  logic [4:0]        tok_q, tok_d;
  logic [4:0]        exp_q, exp_d;
  logic [5:0]        p_q, p_d;
  logic [STK_AW-1:0] base_q, base_d;
  logic [3:0]        n_q, n_d;
  logic [2:0]        i_q, i_d;

  logic       ov_q, ov_d;
  logic [2:0] oact_q, oact_d;
  logic [5:0] oprod_q, oprod_d;
  logic [2:0] oerr_q, oerr_d;
  logic       olast_q, olast_d;

  logic       out_free, in_fire;
  logic       fin;
  logic [2:0] fin_act, fin_err;
  logic       exp_emit, push_last;
  logic [3:0] n_eff;
  logic       ovf;

  assign out_free  = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  assign n_eff     = (len_rdata_q > 4'(MAX_RHS)) ? 4'(MAX_RHS) : len_rdata_q;
  assign ovf       = ({1'b0, sp_q} - 8'd1 + {4'd0, n_eff}) > 8'(STACK_DEPTH);
  assign push_last = ({1'b0, i_q} + 4'd1) == n_q;
  assign exp_emit  = ((state_q == ST_LEN) && !ovf && (n_eff == 4'd0)) ||
                     ((state_q == ST_PUSH) && push_last);

  // final outcome of the parse step in progress
  always_comb begin
    fin     = 1'b0;
    fin_act = ACT_ERROR;
    fin_err = ERR_NONE;
    unique case (state_q)
      ST_READ: begin
        if (sp_q == 7'd0 || sp_q > 7'(STACK_DEPTH)) begin
          fin = 1'b1; fin_err = ERR_MISMATCH;
        end
      end
      ST_TOP: begin
        priority if (stk_rdata_q == {1'b0, tok_q}) begin
          fin = 1'b1;
          fin_act = (tok_q == cfg_i.terminal_count) ? ACT_ACCEPT : ACT_MATCH;
        end else if (!stk_rdata_q[5]) begin
          fin = 1'b1; fin_err = ERR_MISMATCH;
        end else if (exp_q >= 5'(MAX_EXPAND)) begin
          fin = 1'b1; fin_err = ERR_LIMIT;
        end else if ({1'b0, stk_rdata_q[4:0]} >= 6'(NONTERMINALS) ||
                     {1'b0, tok_q} >= 6'(TERMINALS)) begin
          fin = 1'b1; fin_err = ERR_EMPTY;
        end else begin
          fin = 1'b0;
        end
      end
      ST_CELL: begin
        priority if (tbl_rdata_q[7:6] == CELL_EMPTY) begin
          fin = 1'b1; fin_err = ERR_EMPTY;
        end else if (tbl_rdata_q[7:6] != CELL_SINGLE) begin
          fin = 1'b1; fin_err = ERR_AMBIG;
        end else if ({1'b0, tbl_rdata_q[5:0]} >= 7'(PRODUCTIONS)) begin
          fin = 1'b1; fin_err = ERR_EMPTY;
        end else begin
          fin = 1'b0;
        end
      end
      ST_LEN: begin
        if (ovf) begin
          fin = 1'b1; fin_err = ERR_OVERFLOW;
        end
      end
      default: fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == KIND_START) begin
            state_d = ST_SEED;
          end else if (in_i.kind == KIND_TOKEN && run_q &&
                       in_i.token <= cfg_i.terminal_count) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SEED: state_d = ST_IDLE;
      ST_READ: begin
        if (!fin) state_d = ST_TOP;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_TOP, ST_CELL: begin
        if (!fin) state_d = (state_q == ST_TOP) ? ST_CELL : ST_LEN;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_LEN: begin
        if (fin || exp_emit) begin
          if (out_free) state_d = fin ? ST_IDLE : ST_READ;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: if (push_last && out_free) state_d = ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath, memory ports and result register
  always_comb begin
    clr_d   = clr_q;
    sp_d    = sp_q;
    run_d   = run_q;
    tok_d   = tok_q;
    exp_d   = exp_q;
    p_d     = p_q;
    base_d  = base_q;
    n_d     = n_q;
    i_d     = i_q;
    ov_d    = ov_q && !out_o.ready;
    oact_d  = oact_q;
    oprod_d = oprod_q;
    oerr_d  = oerr_q;
    olast_d = olast_q;

    tbl_we = 1'b0; tbl_waddr = {in_i.nonterminal, in_i.column};
    tbl_wdata = {in_i.cell_state, in_i.production};
    tbl_raddr = {stk_rdata_q[4:0], tok_q};
    rhs_we = 1'b0; rhs_waddr = {in_i.production, in_i.position};
    rhs_wdata = in_i.rhs_symbol;
    rhs_raddr = {p_q, 3'(n_q - 4'd2 - {1'b0, i_q})};
    len_we = 1'b0; len_waddr = in_i.production;
    len_wdata = (in_i.rhs_length > 4'(MAX_RHS)) ? 4'(MAX_RHS) : in_i.rhs_length;
    len_raddr = tbl_rdata_q[5:0];
    stk_we = 1'b0; stk_waddr = base_q + STK_AW'(i_q);
    stk_wdata = rhs_rdata_q;
    stk_raddr = STK_AW'(sp_q - 7'd1);

    unique case (state_q)
      ST_CLEAR: begin
        tbl_we = 1'b1; tbl_waddr = clr_q; tbl_wdata = 8'd0;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          ov_d = 1'b1; oact_d = ACT_ACK; oprod_d = 6'd0;
          oerr_d = ERR_NONE; olast_d = 1'b1;
          unique case (in_i.kind)
            KIND_CELL: tbl_we = ({1'b0, in_i.nonterminal} < 6'(NONTERMINALS)) &&
                                ({1'b0, in_i.column} < 6'(TERMINALS));
            KIND_SYM:  rhs_we = ({1'b0, in_i.production} < 7'(PRODUCTIONS)) &&
                                ({1'b0, in_i.position} < 4'(MAX_RHS));
            KIND_LEN:  len_we = {1'b0, in_i.production} < 7'(PRODUCTIONS);
            KIND_START: begin
              stk_we = 1'b1; stk_waddr = '0;
              stk_wdata = {1'b0, cfg_i.terminal_count};
              sp_d = 7'd2; run_d = 1'b1;
            end
            KIND_TOKEN: begin
              tok_d = in_i.token; exp_d = 5'd0;
              if (!run_q) begin
                oact_d = ACT_ERROR; oerr_d = ERR_LIMIT;
              end else if (in_i.token > cfg_i.terminal_count) begin
                oact_d = ACT_ERROR; oerr_d = ERR_BADTOK; run_d = 1'b0;
              end else begin
                ov_d = ov_q && !out_o.ready;
              end
            end
            default: begin
              oact_d = ACT_ERROR; oerr_d = ERR_LIMIT;
            end
          endcase
        end
      end
      ST_SEED: begin
        stk_we = 1'b1; stk_waddr = STK_AW'(1); stk_wdata = cfg_i.start_sym;
      end
      ST_CELL: begin
        p_d = tbl_rdata_q[5:0];
      end
      ST_LEN: begin
        base_d = STK_AW'(sp_q - 7'd1);
        n_d = n_eff;
        i_d = 3'd0;
        rhs_raddr = {p_q, 3'(n_eff - 4'd1)};
      end
      ST_PUSH: begin
        if (!push_last) begin
          stk_we = 1'b1;
          i_d = i_q + 3'd1;
        end else begin
          // keep the last symbol on the read port while the result waits
          rhs_raddr = {p_q, 3'd0};
          stk_we = out_free;
        end
      end
      default: clr_d = clr_q;
    endcase

    if (fin && out_free) begin
      ov_d = 1'b1; oact_d = fin_act; oprod_d = 6'd0; olast_d = 1'b1;
      oerr_d = (fin_act == ACT_ERROR) ? fin_err : ERR_NONE;
      if (fin_act == ACT_MATCH) sp_d = sp_q - 7'd1;
      if (fin_act != ACT_MATCH) run_d = 1'b0;
    end else if (exp_emit && out_free) begin
      ov_d = 1'b1; oact_d = ACT_EXPAND; oprod_d = p_q;
      oerr_d = ERR_NONE; olast_d = 1'b0;
      exp_d = exp_q + 5'd1;
      // empty production just pops the nonterminal
      sp_d = (state_q == ST_LEN) ? sp_q - 7'd1 : 7'({1'b0, base_q}) + 7'(n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sp_q    <= 7'd0;
      run_q   <= 1'b0;
      exp_q   <= 5'd0;
      i_q     <= 3'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      run_q   <= run_d;
      exp_q   <= exp_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    p_q     <= p_d;
    base_q  <= base_d;
    n_q     <= n_d;
    oact_q  <= oact_d;
    oprod_q <= oprod_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  assign out_o.valid              = ov_q;
  assign out_o.action             = oact_q;
  assign out_o.applied_production = oprod_q;
  assign out_o.error_code         = oerr_q;
  assign out_o.last               = olast_q;

endmodule

/* sv/ll1_predictive_parse_engine_core.sv */
// ll1_predictive_parse_engine_core: top level of the table-driven ll(1) parser
// depends on llp_pkg, llp_if, llp_cfg and llp_core
//
//  port      dir   handshake            moves
//  in_i      sink  valid/ready          load, start and token items
//  out_o     src   valid/ready          ack, expand, match, accept, error results
//  apb       sink  psel/penable/pready  start symbol (0x0), terminal count (0x4)
//
// loads, start and rejected tokens are answered from the idle state; a token steps through
// read, top, cell, len and push for each expansion of its right side, then on to its final result,
// in step with the registered reads of the stack, table, length and rule memories
// after reset a pass clears all 1024 entries of the parse table; no item is taken meanwhile
// a stalled result holds the sequencer until the result register frees
module ll1_predictive_parse_engine_core #(
  parameter int unsigned NONTERMINALS = llp_pkg::NONTERMINALS_DEF,
  parameter int unsigned TERMINALS    = llp_pkg::TERMINALS_DEF,
  parameter int unsigned PRODUCTIONS  = llp_pkg::PRODUCTIONS_DEF,
  parameter int unsigned MAX_RHS      = llp_pkg::MAX_RHS_DEF,
  parameter int unsigned STACK_DEPTH  = llp_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_EXPAND   = llp_pkg::MAX_EXPAND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  llp_in_if.sink      in_i,
  llp_out_if.source   out_o
);
  import llp_pkg::*;

  cfg_t cfg;

  llp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  llp_core #(
    .NONTERMINALS (NONTERMINALS),
    .TERMINALS    (TERMINALS),
    .PRODUCTIONS  (PRODUCTIONS),
    .MAX_RHS      (MAX_RHS),
    .STACK_DEPTH  (STACK_DEPTH),
    .MAX_EXPAND   (MAX_EXPAND)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  // an item is only taken when the result register can take its answer
  a_in_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready && out_o.valid |-> out_o.ready) else $error("item taken while result stuck");

  a_expand_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.action == ACT_EXPAND |-> !out_o.last)
    else $error("expand marked last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.action == ACT_ERROR) == (out_o.error_code != ERR_NONE)))
    else $error("error code disagrees with action");
`endif

endmodule
